// File: src/ring_buffer_deque_assert.svh
// Assertion macros for the ring buffer deque.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define RBD_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("ring_buffer_deque: same-cycle check failed");

// Condition holds in the cycle after the trigger
`define RBD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("ring_buffer_deque: next-cycle check failed");

`endif

// File: src/rbd_pkg.sv
// Package for the ring buffer deque: command codes and the result layout.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 3;

    // Command codes; the unused codes act as report only
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REPORT     = 3'd4
    } cmd_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic               refused;
        logic               full_res;
        logic               empty_res;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  back_word;
        logic [WORD_W-1:0]  front_word;
    } result_t;

endpackage

`default_nettype wire

// File: src/rbd_store.sv
// Ring store of the deque: one write port and one read port with registered data.
// Standalone; instantiated by ring_buffer_deque.
`timescale 1ns / 1ps
`default_nettype none

module rbd_store #(
    parameter int DEPTH = 16,
    parameter int DATA_W = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/ring_buffer_deque.sv
// Ring buffer deque top level: command decode, pointer and count, result staging.
// Depends on rbd_pkg, rbd_store and ring_buffer_deque_assert.svh.
//
// A double-ended queue of 32-bit words in a ring memory of CAPACITY entries. Each
// input transaction carries a command in tuser and a word in tdata; each yields one
// result transaction with the front and back words, the count, the empty and full
// flags and a refused flag (push on full, pop on empty). The block takes one
// transaction per cycle while results drain. When a command is taken, head, count
// and the cached end words update and its result enters a pending stage, which the
// output register drains. A pop reads the new end word through the memory's single
// read port; the registered read data is merged into the pending stage and forwarded
// into the cached end words. The memory needs no clearing pass, so commands are taken
// straight after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "ring_buffer_deque_assert.svh"

module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command side
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] cmd
    // Result side
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [71:0] m_axis_tdata    // front_word, back_word, count, empty_res,
                                             // full_res, refused (lowest bit up)
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_S  = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_I = AW'(CAPACITY - 1);

    // Fold a sum below twice the capacity back into the ring
    function automatic logic [AW-1:0] wrap_sum(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= CAP_S) ? s - CAP_S : s;
        return r[AW-1:0];
    endfunction

    // Queue state
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] front_reg, front_next;
    logic [WORD_W-1:0] back_reg, back_next;
    logic              fill_front_reg, fill_front_next;
    logic              fill_back_reg, fill_back_next;

    // Pending result and output register
    logic    p_valid_reg, p_valid_next;
    result_t p_res_reg, p_res_next;
    logic    p_fill_front_reg, p_fill_back_reg;
    logic    o_valid_reg, o_valid_next;
    result_t o_res_reg;
    result_t p_res_eff;

    // Memory ports
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic              s_accept, p_move, refused_next;
    logic              is_full, is_empty;
    logic [WORD_W-1:0] front_cur, back_cur;
    logic [CW+4:0]     count_wide;
    cmd_t              cmd;

    rbd_store #(
        .DEPTH  (CAPACITY),
        .DATA_W (WORD_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake
    assign p_move        = p_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || p_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_res_reg;

    // Forward the word read for the previous pop
    assign front_cur = fill_front_reg ? rd_data : front_reg;
    assign back_cur  = fill_back_reg  ? rd_data : back_reg;
    assign is_full   = (count_reg == CAP_C);
    assign is_empty  = (count_reg == '0);
    assign cmd       = cmd_t'(s_axis_tuser);

    // Decode the command and work out the next queue state
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_cur;
        back_next       = back_cur;
        fill_front_next = 1'b0;
        fill_back_next  = 1'b0;
        refused_next    = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = wrap_sum((AW + 1)'(head_reg) + (AW + 1)'(count_reg));
        rd_en           = 1'b0;
        rd_addr         = wrap_sum((AW + 1)'(head_reg) + (AW + 1)'(count_reg)
                                   - (AW + 1)'(2));
        case (cmd)
            CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    wr_en      = s_accept;
                    count_next = count_reg + 1'b1;
                    back_next  = s_axis_tdata;
                    if (is_empty)
                    begin
                        front_next = s_axis_tdata;
                    end
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    head_next  = (head_reg == '0) ? LAST_I : head_reg - 1'b1;
                    wr_en      = s_accept;
                    wr_addr    = head_next;
                    count_next = count_reg + 1'b1;
                    front_next = s_axis_tdata;
                    if (is_empty)
                    begin
                        back_next = s_axis_tdata;
                    end
                end
            end
            CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    count_next     = count_reg - 1'b1;
                    fill_back_next = (count_next != '0);
                    rd_en          = s_accept && fill_back_next;
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    head_next       = (head_reg == LAST_I) ? '0 : head_reg + 1'b1;
                    count_next      = count_reg - 1'b1;
                    rd_addr         = head_next;
                    fill_front_next = (count_next != '0);
                    rd_en           = s_accept && fill_front_next;
                end
            end
            default:
            begin
                refused_next = 1'b0;
            end
        endcase
    end

    // Build the pending result; a word still being read is filled in later
    always_comb
    begin
        count_wide            = {5'd0, count_next};
        p_res_next.refused    = refused_next;
        p_res_next.full_res   = (count_next == CAP_C);
        p_res_next.empty_res  = (count_next == '0);
        p_res_next.count      = count_wide[COUNT_W-1:0];
        p_res_next.front_word = (count_next == '0) ? '0 : front_next;
        p_res_next.back_word  = (count_next == '0) ? '0 : back_next;
    end

    // Merge the read word into the pending result
    always_comb
    begin
        p_res_eff = p_res_reg;
        if (p_fill_front_reg)
        begin
            p_res_eff.front_word = rd_data;
        end
        if (p_fill_back_reg)
        begin
            p_res_eff.back_word = rd_data;
        end
    end

    assign p_valid_next = s_accept ? 1'b1 : (p_move ? 1'b0 : p_valid_reg);
    assign o_valid_next = p_move ? 1'b1 : (m_axis_tready ? 1'b0 : o_valid_reg);

    // Advance queue state and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            fill_front_reg   <= 1'b0;
            fill_back_reg    <= 1'b0;
            p_valid_reg      <= 1'b0;
            p_fill_front_reg <= 1'b0;
            p_fill_back_reg  <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
            if (s_accept)
            begin
                head_reg         <= head_next;
                count_reg        <= count_next;
                fill_front_reg   <= fill_front_next;
                fill_back_reg    <= fill_back_next;
                p_fill_front_reg <= fill_front_next;
                p_fill_back_reg  <= fill_back_next;
            end
            else
            begin
                fill_front_reg <= 1'b0;
                fill_back_reg  <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        front_reg <= s_accept ? front_next : front_cur;
        back_reg  <= s_accept ? back_next : back_cur;
        if (s_accept)
        begin
            p_res_reg <= p_res_next;
        end
        if (p_move)
        begin
            o_res_reg <= p_res_eff;
        end
    end

    // Count never passes the capacity
    `RBD_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CAP_C)
    // A refused command leaves head and count alone
    `RBD_ASSERT_NEXT(a_refused_holds, s_accept && refused_next,
        $stable(head_reg) && $stable(count_reg))
    // A pop that leaves words behind always fetches the new end word
    `RBD_ASSERT_NEXT(a_pop_fetch, s_accept && (fill_front_next || fill_back_next),
        (fill_front_reg || fill_back_reg) && p_valid_reg)
    // Never take a command while the pending result cannot move
    `RBD_ASSERT_NOW(a_pending_interlock, s_accept, !p_valid_reg || p_move)
    // Memory is never written and read in the same cycle
    `RBD_ASSERT_NOW(a_port_exclusive, wr_en, !rd_en)

endmodule

`default_nettype wire
